// ===== rtl/core/cma_pkg.sv =====
// cma_pkg: shared widths, line lengths and tick periods of the cascaded averager
// depends on nothing; used by every file of the block except cma_checker
`default_nettype none

package cma_pkg;

  // sample and mean width
  localparam int DATA_W    = 32;
  // line length field: lengths up to 64
  localparam int MAX_LEN   = 64;
  localparam int LEN_W     = $clog2(MAX_LEN + 1);
  // running sum holds MAX_LEN full-scale samples plus sign
  localparam int SUM_W     = DATA_W + LEN_W;
  localparam int NUM_LINES = 5;
  localparam int LVL_W     = $clog2(NUM_LINES);

  // sum magnitude and the rounded-up reciprocal that gives an exact truncated mean
  localparam int MAG_W       = DATA_W + $clog2(MAX_LEN);
  localparam int RECIP_SHIFT = MAG_W + $clog2(MAX_LEN);
  localparam int RECIP_W     = RECIP_SHIFT + 1;

  // default line lengths
  localparam int BASE_LEN_DEF   = 5;
  localparam int SECOND_LEN_DEF = 10;
  localparam int THIRD_LEN_DEF  = 30;
  localparam int FOURTH_LEN_DEF = 30;
  localparam int FIFTH_LEN_DEF  = 20;

  // tick periods in ms
  localparam int TICK_MS          = 20;
  localparam int PERIOD_SECOND_MS = 100;
  localparam int PERIOD_FOURTH_MS = 1000;
  localparam int PERIOD_FIFTH_MS  = 30000;

  // nested period counts
  localparam int TICKS_SECOND      = PERIOD_SECOND_MS / TICK_MS;
  localparam int SECONDS_PER_FOURTH = PERIOD_FOURTH_MS / PERIOD_SECOND_MS;
  localparam int FOURTHS_PER_FIFTH  = PERIOD_FIFTH_MS / PERIOD_FOURTH_MS;

  localparam int CSEC_W   = $clog2(TICKS_SECOND);
  localparam int CFOUR_W  = $clog2(SECONDS_PER_FOURTH);
  localparam int CFIFTH_W = $clog2(FOURTHS_PER_FIFTH);

  // line indexes
  localparam logic [LVL_W-1:0] LVL_BASE   = LVL_W'(0);
  localparam logic [LVL_W-1:0] LVL_SECOND = LVL_W'(1);
  localparam logic [LVL_W-1:0] LVL_THIRD  = LVL_W'(2);
  localparam logic [LVL_W-1:0] LVL_FOURTH = LVL_W'(3);
  localparam logic [LVL_W-1:0] LVL_FIFTH  = LVL_W'(4);

  // ring buffer control from the sequencer
  typedef struct packed {
    logic rd_en;
    logic wr_en;
  } ring_ctl_t;

endpackage

`default_nettype wire

// ===== rtl/core/cma_ring.sv =====
// cma_ring: one delay line as a circular memory with a registered read of the oldest entry
// depends on cma_pkg
`default_nettype none

module cma_ring #(
  parameter int DEPTH = cma_pkg::BASE_LEN_DEF
) (
  input  wire                                  clk,
  input  wire                                  rst_n,
  input  cma_pkg::ring_ctl_t                   ctl,
  input  wire logic signed [cma_pkg::DATA_W-1:0] wr_data,
  output logic signed [cma_pkg::DATA_W-1:0]     old_data
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);

  logic signed [cma_pkg::DATA_W-1:0] mem [DEPTH];
  logic [PW-1:0] ptr_r, ptr_nxt;
  logic          full_r, full_nxt;
  logic signed [cma_pkg::DATA_W-1:0] rd_data_r;
  logic          rd_valid_r;

  // write pointer wraps over the line; full once every entry holds a sample
  always_comb begin
    ptr_nxt  = ptr_r;
    full_nxt = full_r;
    if (ctl.wr_en) begin
      if (ptr_r == LAST) begin
        ptr_nxt  = '0;
        full_nxt = 1'b1;
      end else begin
        ptr_nxt = ptr_r + PW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ptr_r      <= '0;
      full_r     <= 1'b0;
      rd_valid_r <= 1'b0;
    end else begin
      ptr_r  <= ptr_nxt;
      full_r <= full_nxt;
      if (ctl.rd_en) begin
        rd_valid_r <= full_r;
      end
    end
  end

  // memory write and registered read of the oldest slot
  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem[ptr_r] <= wr_data;
    end
    if (ctl.rd_en) begin
      rd_data_r <= mem[ptr_r];
    end
  end

  // never-written slots read as zero
  assign old_data = rd_valid_r ? rd_data_r : '0;

endmodule

`default_nettype wire

// ===== rtl/core/cma_div.sv =====
// cma_div: shared mean unit, line sum times a rounded-up length reciprocal, truncates toward zero
// four half-width partial products; depends on cma_pkg
`default_nettype none

module cma_div (
  input  wire                                   clk,
  input  wire                                   rst_n,
  input  wire                                   start,
  input  wire logic signed [cma_pkg::SUM_W-1:0] dividend,
  input  wire logic [cma_pkg::RECIP_W-1:0]      recip,
  output logic                                  done,
  output logic signed [cma_pkg::DATA_W-1:0]     quot
);

  localparam int DW = cma_pkg::DATA_W;
  localparam int MW = cma_pkg::MAG_W;
  localparam int RW = cma_pkg::RECIP_W;
  localparam int RS = cma_pkg::RECIP_SHIFT;
  localparam int HA = (MW + 1) / 2;
  localparam int HB = (RW + 1) / 2;
  localparam int A2 = 2 * HA;
  localparam int B2 = 2 * HB;
  localparam int PW = HA + HB;
  localparam int AW = 2 * PW;
  localparam logic [2:0] LAST_STEP = 3'd4;

  logic          busy_r, done_r, neg_r;
  logic [2:0]    step_r;
  logic [A2-1:0] a_r;
  logic [B2-1:0] b_r;
  logic [PW-1:0] pp_r;
  logic [AW-1:0] acc_r;

  logic [cma_pkg::SUM_W-1:0] mag;
  logic [HA-1:0]             a_half;
  logic [HB-1:0]             b_half;
  logic [AW-1:0]             pp_term;
  logic [DW-1:0]             q;

  // magnitude of the dividend; it always fits in MAG_W bits
  assign mag = dividend[cma_pkg::SUM_W-1] ? (-dividend) : dividend;

  // operand halves of the current partial product
  always_comb begin
    unique case (step_r)
      3'd0: begin
        a_half = a_r[HA-1:0];
        b_half = b_r[HB-1:0];
      end
      3'd1: begin
        a_half = a_r[A2-1:HA];
        b_half = b_r[HB-1:0];
      end
      3'd2: begin
        a_half = a_r[HA-1:0];
        b_half = b_r[B2-1:HB];
      end
      3'd3: begin
        a_half = a_r[A2-1:HA];
        b_half = b_r[B2-1:HB];
      end
      default: begin
        a_half = '0;
        b_half = '0;
      end
    endcase
  end

  // previous partial product aligned to its weight
  always_comb begin
    unique case (step_r)
      3'd1:    pp_term = AW'(pp_r);
      3'd2:    pp_term = AW'(pp_r) << HA;
      3'd3:    pp_term = AW'(pp_r) << HB;
      3'd4:    pp_term = AW'(pp_r) << PW;
      default: pp_term = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
      end else if (busy_r && step_r == LAST_STEP) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  // datapath: multiply one half pair, accumulate the one before
  always_ff @(posedge clk) begin
    if (start) begin
      neg_r  <= dividend[cma_pkg::SUM_W-1];
      a_r    <= A2'(mag);
      b_r    <= B2'(recip);
      acc_r  <= '0;
      step_r <= '0;
    end else if (busy_r) begin
      pp_r   <= PW'(a_half) * PW'(b_half);
      acc_r  <= acc_r + pp_term;
      step_r <= step_r + 3'd1;
    end
  end

  assign q    = acc_r[RS +: DW];
  assign done = done_r;
  assign quot = neg_r ? (-q) : q;

endmodule

`default_nettype wire

// ===== rtl/core/cascaded_multirate_averager.sv =====
// sequence: the base line moves on every sample and each further line that is due follows it,
// up to five lines; each line takes read, update, start and a wait on the shared reciprocal
// multiplier, and a new sample is taken only once all lines are through and the result has
// moved to the output register
// the result sits in an output register, so the next sample is taken while it waits
// reset: synchronous active-low; all lines read as zero, tick counters and means cleared
`default_nettype none

module cascaded_multirate_averager #(
  parameter int BASE_LEN   = cma_pkg::BASE_LEN_DEF,
  parameter int SECOND_LEN = cma_pkg::SECOND_LEN_DEF,
  parameter int THIRD_LEN  = cma_pkg::THIRD_LEN_DEF,
  parameter int FOURTH_LEN = cma_pkg::FOURTH_LEN_DEF,
  parameter int FIFTH_LEN  = cma_pkg::FIFTH_LEN_DEF
) (
  input  wire          clk,
  input  wire          rst_n,
  input  wire          in_tvalid,
  output logic         in_tready,
  input  wire  [31:0]  in_tdata,   // [31:0] sample
  output logic         out_tvalid,
  input  wire          out_tready,
  // [31:0] mean_base, [63:32] mean_second, [95:64] mean_third,
  // [127:96] mean_fourth, [159:128] mean_fifth
  output logic [159:0] out_tdata
);

  localparam int DW = cma_pkg::DATA_W;
  localparam int SW = cma_pkg::SUM_W;
  localparam int RW = cma_pkg::RECIP_W;
  localparam int RS = cma_pkg::RECIP_SHIFT;
  localparam int NL = cma_pkg::NUM_LINES;
  localparam int VW = cma_pkg::LVL_W;

  // sequencer states
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_RD   = 3'd1;
  localparam logic [2:0] S_UPD  = 3'd2;
  localparam logic [2:0] S_GO   = 3'd3;
  localparam logic [2:0] S_WAIT = 3'd4;
  localparam logic [2:0] S_OUT  = 3'd5;

  localparam logic [cma_pkg::CSEC_W-1:0]   CSEC_LAST   =
    cma_pkg::CSEC_W'(cma_pkg::TICKS_SECOND - 1);
  localparam logic [cma_pkg::CFOUR_W-1:0]  CFOUR_LAST  =
    cma_pkg::CFOUR_W'(cma_pkg::SECONDS_PER_FOURTH - 1);
  localparam logic [cma_pkg::CFIFTH_W-1:0] CFIFTH_LAST =
    cma_pkg::CFIFTH_W'(cma_pkg::FOURTHS_PER_FIFTH - 1);

  // mean reciprocals of the line lengths, rounded up
  localparam logic [RW-1:0] RCP_BASE   =
    RW'(((64'd1 << RS) + 64'(BASE_LEN) - 64'd1) / 64'(BASE_LEN));
  localparam logic [RW-1:0] RCP_SECOND =
    RW'(((64'd1 << RS) + 64'(SECOND_LEN) - 64'd1) / 64'(SECOND_LEN));
  localparam logic [RW-1:0] RCP_THIRD  =
    RW'(((64'd1 << RS) + 64'(THIRD_LEN) - 64'd1) / 64'(THIRD_LEN));
  localparam logic [RW-1:0] RCP_FOURTH =
    RW'(((64'd1 << RS) + 64'(FOURTH_LEN) - 64'd1) / 64'(FOURTH_LEN));
  localparam logic [RW-1:0] RCP_FIFTH  =
    RW'(((64'd1 << RS) + 64'(FIFTH_LEN) - 64'd1) / 64'(FIFTH_LEN));

  logic [2:0]    state_r, state_nxt;
  logic [VW-1:0] lvl_r, lvl_nxt;

  logic [cma_pkg::CSEC_W-1:0]   csec_r;
  logic [cma_pkg::CFOUR_W-1:0]  cfour_r;
  logic [cma_pkg::CFIFTH_W-1:0] cfifth_r;
  logic sec_r, four_r, fifth_r;

  logic signed [DW-1:0] sample_r;
  logic signed [SW-1:0] sum_r  [NL];
  logic signed [DW-1:0] mean_r [NL];

  logic                 out_valid_r;
  logic [159:0]         out_data_r;

  cma_pkg::ring_ctl_t   ctl [NL];
  logic signed [DW-1:0] old_data [NL];
  logic signed [DW-1:0] push_val, old_sel;
  logic [RW-1:0]        recip_sel;
  logic signed [SW-1:0] sum_upd;

  logic                 div_done;
  logic signed [DW-1:0] div_q;

  logic in_xfer, out_free;

  assign in_xfer  = in_tvalid && in_tready;
  assign out_free = !out_valid_r || out_tready;
  assign in_tready = (state_r == S_IDLE);

  // value pushed into the current line and its mean reciprocal
  always_comb begin
    unique case (lvl_r)
      cma_pkg::LVL_BASE: begin
        push_val  = sample_r;
        old_sel   = old_data[0];
        recip_sel = RCP_BASE;
      end
      cma_pkg::LVL_SECOND: begin
        push_val  = mean_r[0];
        old_sel   = old_data[1];
        recip_sel = RCP_SECOND;
      end
      cma_pkg::LVL_THIRD: begin
        push_val  = mean_r[1];
        old_sel   = old_data[2];
        recip_sel = RCP_THIRD;
      end
      cma_pkg::LVL_FOURTH: begin
        push_val  = mean_r[1];
        old_sel   = old_data[3];
        recip_sel = RCP_FOURTH;
      end
      cma_pkg::LVL_FIFTH: begin
        push_val  = mean_r[3];
        old_sel   = old_data[4];
        recip_sel = RCP_FIFTH;
      end
      default: begin
        push_val  = '0;
        old_sel   = '0;
        recip_sel = '0;
      end
    endcase
  end

  // running sum: add the new entry, drop the oldest
  assign sum_upd = sum_r[lvl_r]
                 + {{(SW-DW){push_val[DW-1]}}, push_val}
                 - {{(SW-DW){old_sel[DW-1]}}, old_sel};

  // ring control per line
  always_comb begin
    for (int i = 0; i < NL; i++) begin
      ctl[i].rd_en = (state_r == S_RD)  && (lvl_r == VW'(i));
      ctl[i].wr_en = (state_r == S_UPD) && (lvl_r == VW'(i));
    end
  end

  // sequencer: one line at a time through read, update, mean
  always_comb begin
    state_nxt = state_r;
    lvl_nxt   = lvl_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          state_nxt = S_RD;
          lvl_nxt   = cma_pkg::LVL_BASE;
        end
      end
      S_RD:  state_nxt = S_UPD;
      S_UPD: state_nxt = S_GO;
      S_GO:  state_nxt = S_WAIT;
      S_WAIT: begin
        if (div_done) begin
          state_nxt = S_OUT;
          unique case (lvl_r)
            cma_pkg::LVL_BASE: begin
              if (sec_r) begin
                state_nxt = S_RD;
                lvl_nxt   = cma_pkg::LVL_SECOND;
              end
            end
            cma_pkg::LVL_SECOND: begin
              state_nxt = S_RD;
              lvl_nxt   = cma_pkg::LVL_THIRD;
            end
            cma_pkg::LVL_THIRD: begin
              if (four_r) begin
                state_nxt = S_RD;
                lvl_nxt   = cma_pkg::LVL_FOURTH;
              end
            end
            cma_pkg::LVL_FOURTH: begin
              if (fifth_r) begin
                state_nxt = S_RD;
                lvl_nxt   = cma_pkg::LVL_FIFTH;
              end
            end
            default: state_nxt = S_OUT;
          endcase
        end
      end
      S_OUT: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      lvl_r   <= cma_pkg::LVL_BASE;
    end else begin
      state_r <= state_nxt;
      lvl_r   <= lvl_nxt;
    end
  end

  // nested tick counters and the update flags of the current sample
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      csec_r   <= '0;
      cfour_r  <= '0;
      cfifth_r <= '0;
      sec_r    <= 1'b0;
      four_r   <= 1'b0;
      fifth_r  <= 1'b0;
    end else if (in_xfer) begin
      sec_r   <= (csec_r == CSEC_LAST);
      four_r  <= (csec_r == CSEC_LAST) && (cfour_r == CFOUR_LAST);
      fifth_r <= (csec_r == CSEC_LAST) && (cfour_r == CFOUR_LAST)
              && (cfifth_r == CFIFTH_LAST);
      if (csec_r == CSEC_LAST) begin
        csec_r <= '0;
        if (cfour_r == CFOUR_LAST) begin
          cfour_r  <= '0;
          cfifth_r <= (cfifth_r == CFIFTH_LAST) ? '0 : cfifth_r + cma_pkg::CFIFTH_W'(1);
        end else begin
          cfour_r <= cfour_r + cma_pkg::CFOUR_W'(1);
        end
      end else begin
        csec_r <= csec_r + cma_pkg::CSEC_W'(1);
      end
    end
  end

  // sample capture
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      sample_r <= $signed(in_tdata);
    end
  end

  // running sums and cached means
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NL; i++) begin
        sum_r[i]  <= '0;
        mean_r[i] <= '0;
      end
    end else begin
      if (state_r == S_UPD) begin
        sum_r[lvl_r] <= sum_upd;
      end
      if (state_r == S_WAIT && div_done) begin
        mean_r[lvl_r] <= div_q;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == S_OUT && out_free) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_OUT && out_free) begin
      out_data_r <= {mean_r[4], mean_r[3], mean_r[2], mean_r[1], mean_r[0]};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // delay lines
  cma_ring #(.DEPTH(BASE_LEN)) u_ring_base (
    .clk(clk), .rst_n(rst_n), .ctl(ctl[0]), .wr_data(push_val), .old_data(old_data[0])
  );
  cma_ring #(.DEPTH(SECOND_LEN)) u_ring_second (
    .clk(clk), .rst_n(rst_n), .ctl(ctl[1]), .wr_data(push_val), .old_data(old_data[1])
  );
  cma_ring #(.DEPTH(THIRD_LEN)) u_ring_third (
    .clk(clk), .rst_n(rst_n), .ctl(ctl[2]), .wr_data(push_val), .old_data(old_data[2])
  );
  cma_ring #(.DEPTH(FOURTH_LEN)) u_ring_fourth (
    .clk(clk), .rst_n(rst_n), .ctl(ctl[3]), .wr_data(push_val), .old_data(old_data[3])
  );
  cma_ring #(.DEPTH(FIFTH_LEN)) u_ring_fifth (
    .clk(clk), .rst_n(rst_n), .ctl(ctl[4]), .wr_data(push_val), .old_data(old_data[4])
  );

  // shared mean unit for all lines
  cma_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (state_r == S_GO),
    .dividend (sum_r[lvl_r]),
    .recip    (recip_sel),
    .done     (div_done),
    .quot     (div_q)
  );

endmodule

`default_nettype wire

// ===== rtl/core/cma_checker.sv =====
// cma_checker: port-level assertions for the cascaded averager, bound to the top level
// depends on cascaded_multirate_averager ports only
`default_nettype none

module cma_checker (
  input wire         clk,
  input wire         rst_n,
  input wire         in_tvalid,
  input wire         in_tready,
  input wire         out_tvalid,
  input wire         out_tready,
  input wire [159:0] out_tdata
);

  // a sample in work blocks further input
  assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input taken while a sample is in work");

  // a new result only appears when the sequencer is back to idle
  assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> in_tready)
    else $error("result shown while sequencer busy");

  // stalled result holds
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result changed");

  // no result can follow an input transfer in the next cycle
  assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && !out_tvalid |=> !out_tvalid)
    else $error("result appeared without sequencer work");

endmodule

bind cascaded_multirate_averager cma_checker u_cma_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

`default_nettype wire

// ===== tb/sv/cascaded_multirate_averager_tb.sv =====
// cascaded_multirate_averager_tb: self-checking bench for the cascaded averager with a
// queue-fed stream driver, a checking monitor and a line-by-line predictor of all five means
// depends on cma_pkg and cascaded_multirate_averager
`timescale 1ns / 1ps

module cascaded_multirate_averager_tb;

  localparam int NUM_ITEMS   = 1900;
  localparam int IDLE_PCT    = 27;
  localparam int CALM_FIRST  = 900;
  localparam int CALM_LAST   = 1200;
  localparam int HOLD_AT     = 250;
  localparam int HOLD_CYCLES = 600;
  localparam int DRAIN_WAIT  = 400;
  localparam int MAX_DEPTH   = 30;
  localparam int NL          = cma_pkg::NUM_LINES;
  localparam int VW          = cma_pkg::LVL_W;
  localparam int TICKS_FOURTH = cma_pkg::TICKS_SECOND * cma_pkg::SECONDS_PER_FOURTH;
  localparam int TICKS_FIFTH  = TICKS_FOURTH * cma_pkg::FOURTHS_PER_FIFTH;
  localparam logic [31:0] S_MAX = 32'h7FFF_FFFF;
  localparam logic [31:0] S_MIN = 32'h8000_0000;

  logic         clk        = 1'b0;
  logic         rst_n      = 1'b0;
  logic         in_tvalid  = 1'b0;
  logic         in_tready;
  logic [31:0]  in_tdata   = '0;     // [31:0] sample
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  // [31:0] mean_base, [63:32] mean_second, [95:64] mean_third,
  // [127:96] mean_fourth, [159:128] mean_fifth
  logic [159:0] out_tdata;

  cascaded_multirate_averager u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  always #5 clk = ~clk;

  // predictor state: five delay lines, newest at index 0, and the tick counter
  int line_len [NL] = '{cma_pkg::BASE_LEN_DEF, cma_pkg::SECOND_LEN_DEF,
                        cma_pkg::THIRD_LEN_DEF, cma_pkg::FOURTH_LEN_DEF,
                        cma_pkg::FIFTH_LEN_DEF};
  logic signed [31:0] line_buf [NL][MAX_DEPTH];
  int tick_cnt;

  logic [31:0]  pending_samples_q [$];
  logic [159:0] expected_means_q [$];
  int samples_sent  = 0;
  int means_checked = 0;
  int mismatches    = 0;
  int hold_left     = 0;
  bit hold_done     = 1'b0;
  string field_name [NL] = '{"mean_base", "mean_second", "mean_third",
                             "mean_fourth", "mean_fifth"};

  initial begin
    for (int l = 0; l < NL; l++)
      for (int i = 0; i < MAX_DEPTH; i++) line_buf[l][i] = '0;
    tick_cnt = 0;
  end

  function automatic void push_line(logic [VW-1:0] lvl, logic signed [31:0] v);
    for (int i = line_len[lvl] - 1; i > 0; i--) line_buf[lvl][i] = line_buf[lvl][i-1];
    line_buf[lvl][0] = v;
  endfunction

  // exact sum over the line, divided with truncation toward zero
  function automatic logic signed [31:0] line_mean(logic [VW-1:0] lvl);
    longint sum;
    sum = 0;
    for (int i = 0; i < line_len[lvl]; i++) sum += longint'(line_buf[lvl][i]);
    return 32'(sum / longint'(line_len[lvl]));
  endfunction

  // advance the lines that move on this tick and queue the five means that follow
  function automatic void advance_averager(logic [31:0] sample);
    logic signed [31:0] m;
    logic [159:0] means;
    push_line(cma_pkg::LVL_BASE, $signed(sample));
    tick_cnt++;
    if (tick_cnt % cma_pkg::TICKS_SECOND == 0) begin
      push_line(cma_pkg::LVL_SECOND, line_mean(cma_pkg::LVL_BASE));
      m = line_mean(cma_pkg::LVL_SECOND);
      push_line(cma_pkg::LVL_THIRD, m);
      if (tick_cnt % TICKS_FOURTH == 0) begin
        push_line(cma_pkg::LVL_FOURTH, m);
        if (tick_cnt % TICKS_FIFTH == 0) begin
          push_line(cma_pkg::LVL_FIFTH, line_mean(cma_pkg::LVL_FOURTH));
          tick_cnt = 0;
        end
      end
    end
    if (tick_cnt >= TICKS_FIFTH) tick_cnt = 0;
    for (int k = 0; k < NL; k++) means[k*32 +: 32] = line_mean(VW'(k));
    expected_means_q.push_back(means);
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch on result %0d: %s got %0d expected %0d", means_checked, what,
             $signed(got), $signed(want));
    mismatches++;
  endtask

  // sample driver: holds an item until its transfer, then offers the next one
  always @(posedge clk) begin : sample_driver
    bit idle_now;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        advance_averager(in_tdata);
        samples_sent <= samples_sent + 1;
      end
      if (!in_tvalid || in_tready) begin
        idle_now = !(samples_sent >= CALM_FIRST && samples_sent < CALM_LAST) &&
                   ($urandom_range(99) < IDLE_PCT);
        if (pending_samples_q.size() > 0 && !idle_now) begin
          in_tvalid <= 1'b1;
          in_tdata  <= pending_samples_q.pop_front();
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // long receiver hold-off, once, so the block fills and stalls its input
  always @(posedge clk) begin
    if (!rst_n) begin
      hold_left <= 0;
    end else if (!hold_done && means_checked >= HOLD_AT) begin
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // result monitor: compare each transfer with the oldest expected means
  always @(posedge clk) begin : means_monitor
    logic [159:0] want;
    bit calm;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (expected_means_q.size() == 0) begin
          report_mismatch("result with no sample pending", out_tdata[31:0], '0);
        end else begin
          want = expected_means_q.pop_front();
          for (int k = 0; k < NL; k++)
            if (out_tdata[k*32 +: 32] !== want[k*32 +: 32])
              report_mismatch(field_name[k], out_tdata[k*32 +: 32], want[k*32 +: 32]);
        end
        means_checked <= means_checked + 1;
      end
      calm = means_checked >= CALM_FIRST && means_checked < CALM_LAST;
      if (hold_left > 0)
        out_tready <= 1'b0;
      else
        out_tready <= calm || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  // stimulus and end of run
  initial begin
    int kind;
    int run;
    logic [31:0] v;
    // directed: extremes, sign patterns, truncation of negative means
    repeat (5) pending_samples_q.push_back(S_MAX);
    repeat (5) pending_samples_q.push_back(S_MIN);
    pending_samples_q.push_back(32'hFFFF_FFFF);
    repeat (4) pending_samples_q.push_back(32'h0);
    pending_samples_q.push_back(32'hFFFF_FFF9);
    pending_samples_q.push_back(32'h0000_0001);
    pending_samples_q.push_back(32'hAAAA_AAAA);
    pending_samples_q.push_back(32'h5555_5555);
    pending_samples_q.push_back(S_MIN + 32'd1);
    pending_samples_q.push_back(S_MAX - 32'd1);
    pending_samples_q.push_back(32'hFFFF_FFFE);
    pending_samples_q.push_back(32'h0000_0003);
    pending_samples_q.push_back(32'hFFFF_FFFD);
    // random: full range half the time, with small values, near-extremes and saturating runs
    while (pending_samples_q.size() < NUM_ITEMS) begin
      kind = $urandom_range(99);
      if (kind < 50) begin
        pending_samples_q.push_back($urandom);
      end else if (kind < 70) begin
        pending_samples_q.push_back(32'($signed($urandom_range(40)) - 20));
      end else if (kind < 85) begin
        v = $urandom_range(1) ? S_MAX - $urandom_range(3) : S_MIN + $urandom_range(3);
        pending_samples_q.push_back(v);
      end else if (kind < 88) begin
        run = $urandom_range(60, 5);
        v = $urandom_range(1) ? S_MAX : S_MIN;
        repeat (run) pending_samples_q.push_back(v);
      end else begin
        pending_samples_q.push_back(32'($signed($urandom_range(2000)) - 1000));
      end
    end

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    wait (pending_samples_q.size() == 0 && !in_tvalid && expected_means_q.size() == 0);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (mismatches == 0 && expected_means_q.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // run limit
  initial begin
    #25_000_000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule

// ===== files.f =====
rtl/core/cma_pkg.sv
rtl/core/cma_ring.sv
rtl/core/cma_div.sv
rtl/core/cascaded_multirate_averager.sv
rtl/core/cma_checker.sv
tb/sv/cascaded_multirate_averager_tb.sv
